// ===== rtl/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg: shared constants and types for the k-means cluster engine
// Sizes of the sample store and centroid set, derived widths, command and
// configuration register codes, and the state machine types.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

  localparam int SAMPLE_DEPTH  = 256;
  localparam int NUM_CLUSTERS  = 2;
  localparam int NUM_FEATURES  = 4;
  localparam int FEATURE_WIDTH = 16;

  // Derived widths.
  localparam int SIW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int FIW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CIW   = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int SAW   = SIW + FIW;
  localparam int CNTW  = SIW + 1;
  localparam int SUMW  = FEATURE_WIDTH + SIW + 1;
  localparam int DISTW = 2 * FEATURE_WIDTH + FIW;
  localparam int STEPW = $clog2(SUMW);

  // Command codes.
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_RUN    = 2'd1;
  localparam logic [1:0] CMD_RLABEL = 2'd2;
  localparam logic [1:0] CMD_RCENT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SEED_SAMPLE  = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RLABEL,
    ST_ISSUE,
    ST_WAIT1,
    ST_WAIT2,
    ST_EVAL,
    ST_ITER,
    ST_UPDATE,
    ST_DWAIT,
    ST_ITEREND,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_SCAN,
    MODE_ASSIGN
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/kmc_div.sv =====
// ----------------------------------------------------------------------------
// kmc_div: sequential signed-by-unsigned divider
// Restoring division of a member sum by a member count, one quotient bit per
// cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_div (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    start,
  input  wire logic signed [kmc_pkg::SUMW-1:0]   dividend,
  input  wire logic [kmc_pkg::CNTW-1:0]          divisor,
  output logic signed [kmc_pkg::FEATURE_WIDTH-1:0] quotient,
  output logic                                   done
);
  import kmc_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [STEPW-1:0] step_r;
  logic [SUMW-1:0]  quo_r;
  logic [CNTW-1:0]  rem_r;
  logic [CNTW-1:0]  den_r;
  logic [CNTW:0]    trial;
  logic             ge;
  logic [SUMW-1:0]  quo_signed;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[SUMW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEPW'(SUMW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[SUMW-1] ? (-dividend) : dividend;
      neg_r <= dividend[SUMW-1];
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? CNTW'(trial - {1'b0, den_r}) : trial[CNTW-1:0];
      quo_r <= {quo_r[SUMW-2:0], ge};
    end
  end

  // Apply the sign and keep the feature width.
  assign quo_signed = neg_r ? (-quo_r) : quo_r;
  assign quotient   = quo_signed[FEATURE_WIDTH-1:0];
  assign done       = done_r;

endmodule

`default_nettype wire

// ===== rtl/kmeans_cluster_engine.sv =====
// ----------------------------------------------------------------------------
// kmeans_cluster_engine: k-means clustering over a sample store
// Write-feature and read-centroid requests answer in the cycle after
// acceptance; read-label requests pass through ST_RLABEL first. A run seeds
// by farthest point, then iterates assignment and mean update; each sample
// visit reads its features through the sample memory port, and each centroid
// feature of a non-empty cluster goes through the shared divider.
// Reset is synchronous: labels read zero, centroids and run status clear.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_cluster_engine (
  input  wire         clk,
  input  wire         rst_n,
  // Fields from bit 0: command[1:0], sample_index[9:2], cluster_index[12:10],
  // feature_index[15:13], feature_value[31:16].
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,
  // Fields from bit 0: read_value[15:0], converged[16],
  // iterations_used[24:17], zero fill.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [8:0]  cfg_data
);
  import kmc_pkg::*;

  localparam int SDEPTH = SAMPLE_DEPTH * (2 ** FIW);

  // Input fields.
  logic [1:0]  in_cmd;
  logic [7:0]  in_si;
  logic [2:0]  in_ci;
  logic [2:0]  in_fi;
  logic [15:0] in_fv;
  logic        in_acc;

  assign in_cmd = in_tdata[1:0];
  assign in_si  = in_tdata[9:2];
  assign in_ci  = in_tdata[12:10];
  assign in_fi  = in_tdata[15:13];
  assign in_fv  = in_tdata[31:16];
  assign in_acc = in_tvalid && in_tready;

  // Control state.
  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [SIW-1:0]   s_r, s_nxt;
  logic [FIW-1:0]   f_r, f_nxt;
  logic [SIW-1:0]   n_last_r, n_last_nxt;
  logic [SIW-1:0]   pick_r, pick_nxt;
  logic [DISTW-1:0] best_r, best_nxt;
  logic             have_r, have_nxt;
  logic [CIW-1:0]   c_idx_r, c_idx_nxt;
  logic [7:0]       it_r, it_nxt;
  logic [1:0]       uc_r, uc_nxt;
  logic             changed_r, changed_nxt;
  logic             conv_pend_r, conv_pend_nxt;
  logic [CIW-1:0]   uc_c_r, uc_c_nxt;
  logic [FIW-1:0]   uc_f_r, uc_f_nxt;
  logic             conv_r, conv_nxt;
  logic [7:0]       used_r, used_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  // Configuration registers.
  logic [8:0] cnt_cfg_r;
  logic [7:0] seed_cfg_r;
  logic [7:0] lim_cfg_r;

  // Datapath storage.
  logic signed [FEATURE_WIDTH-1:0] cent_r [NUM_CLUSTERS][NUM_FEATURES];
  logic signed [SUMW-1:0]          sum_r  [NUM_CLUSTERS][NUM_FEATURES];
  logic [CNTW-1:0]                 mcnt_r [NUM_CLUSTERS];
  logic signed [FEATURE_WIDTH-1:0] buf_r  [NUM_FEATURES];
  logic [DISTW-1:0]                dist_r [NUM_CLUSTERS];
  logic [2*FEATURE_WIDTH-1:0]      sq_r   [NUM_CLUSTERS];
  logic                            rd_vld_r, sq_vld_r;
  logic [FIW-1:0]                  rd_f_r, sq_f_r;

  // Sample and label memories.
  logic [FEATURE_WIDTH-1:0] smem [SDEPTH];
  logic [FEATURE_WIDTH-1:0] smem_q_r;
  logic [SAW-1:0]           smem_waddr;
  logic                     smem_we;
  logic [CIW-1:0]           lmem [SAMPLE_DEPTH];
  logic [CIW-1:0]           lmem_q_r;
  logic [SAMPLE_DEPTH-1:0]  lvld_r;
  logic                     lvld_q_r;

  // Combinational helpers.
  logic [31:0]      n_eff;
  logic [DISTW-1:0] near;
  logic [CIW-1:0]   bc;
  logic [DISTW-1:0] bd;
  logic             scan_upd;
  logic             div_start, div_done;
  logic signed [FEATURE_WIDTH-1:0] div_quo;
  logic [15:0]      cent_rd;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Effective sample count: zero acts as one, larger counts clamp to the store size.
  always_comb begin
    if (cnt_cfg_r == 9'd0) begin
      n_eff = 32'd1;
    end else if (32'(cnt_cfg_r) > SAMPLE_DEPTH) begin
      n_eff = 32'(SAMPLE_DEPTH);
    end else begin
      n_eff = 32'(cnt_cfg_r);
    end
  end

  // Nearest chosen centroid during seeding, and nearest centroid overall.
  always_comb begin
    near = dist_r[0];
    bd   = dist_r[0];
    bc   = '0;
    for (int k = 1; k < NUM_CLUSTERS; k++) begin
      if ((CIW'(k) <= c_idx_r) && (dist_r[k] < near)) begin
        near = dist_r[k];
      end
      if (dist_r[k] < bd) begin
        bd = dist_r[k];
        bc = CIW'(k);
      end
    end
  end

  assign scan_upd  = !have_r || (near > best_r);
  assign div_start = (state_r == ST_UPDATE) && (mcnt_r[uc_c_r] != '0);

  // Centroid read request, zero outside the cluster and feature range.
  always_comb begin
    cent_rd = '0;
    if ((32'(in_ci) < NUM_CLUSTERS) && (32'(in_fi) < NUM_FEATURES)) begin
      cent_rd = 16'(cent_r[in_ci[CIW-1:0]][in_fi[FIW-1:0]]);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r  <= 9'd256;
      seed_cfg_r <= 8'd0;
      lim_cfg_r  <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: cnt_cfg_r  <= cfg_data;
        CFG_SEED_SAMPLE:  seed_cfg_r <= cfg_data[7:0];
        CFG_ITER_LIMIT:   lim_cfg_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state and control registers.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    s_nxt         = s_r;
    f_nxt         = f_r;
    n_last_nxt    = n_last_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    c_idx_nxt     = c_idx_r;
    it_nxt        = it_r;
    uc_nxt        = uc_r;
    changed_nxt   = changed_r;
    conv_pend_nxt = conv_pend_r;
    uc_c_nxt      = uc_c_r;
    uc_f_nxt      = uc_f_r;
    conv_nxt      = conv_r;
    used_nxt      = used_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_WRITE: begin
              out_vld_nxt  = 1'b1;
              out_data_nxt = {7'd0, used_r, conv_r, 16'd0};
            end
            CMD_RUN: begin
              n_last_nxt = SIW'(n_eff - 32'd1);
              pick_nxt   = (32'(seed_cfg_r) < n_eff) ? SIW'(seed_cfg_r) : '0;
              s_nxt      = (32'(seed_cfg_r) < n_eff) ? SIW'(seed_cfg_r) : '0;
              f_nxt      = '0;
              c_idx_nxt  = '0;
              mode_nxt   = MODE_LOAD;
              state_nxt  = ST_ISSUE;
            end
            CMD_RLABEL: begin
              state_nxt = ST_RLABEL;
            end
            default: begin
              out_vld_nxt  = 1'b1;
              out_data_nxt = {7'd0, used_r, conv_r, cent_rd};
            end
          endcase
        end
      end
      ST_RLABEL: begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = {7'd0, used_r, conv_r, (lvld_q_r ? 16'(lmem_q_r) : 16'd0)};
        state_nxt    = ST_IDLE;
      end
      ST_ISSUE: begin
        f_nxt = f_r + 1'b1;
        if (f_r == FIW'(NUM_FEATURES - 1)) begin
          f_nxt     = '0;
          state_nxt = ST_WAIT1;
        end
      end
      ST_WAIT1: state_nxt = ST_WAIT2;
      ST_WAIT2: state_nxt = ST_EVAL;
      ST_EVAL: begin
        case (mode_r)
          MODE_LOAD: begin
            if (c_idx_r == CIW'(NUM_CLUSTERS - 1)) begin
              it_nxt        = '0;
              uc_nxt        = '0;
              conv_pend_nxt = 1'b0;
              state_nxt     = ST_ITER;
            end else begin
              mode_nxt  = MODE_SCAN;
              s_nxt     = '0;
              have_nxt  = 1'b0;
              state_nxt = ST_ISSUE;
            end
          end
          MODE_SCAN: begin
            if (scan_upd) begin
              best_nxt = near;
              pick_nxt = s_r;
            end
            have_nxt  = 1'b1;
            state_nxt = ST_ISSUE;
            if (s_r == n_last_r) begin
              c_idx_nxt = c_idx_r + 1'b1;
              mode_nxt  = MODE_LOAD;
              s_nxt     = scan_upd ? s_r : pick_r;
            end else begin
              s_nxt = s_r + 1'b1;
            end
          end
          default: begin
            if (s_r == n_last_r) begin
              uc_c_nxt    = '0;
              uc_f_nxt    = '0;
              changed_nxt = 1'b0;
              state_nxt   = ST_UPDATE;
            end else begin
              s_nxt     = s_r + 1'b1;
              state_nxt = ST_ISSUE;
            end
          end
        endcase
      end
      ST_ITER: begin
        if (it_r == lim_cfg_r) begin
          state_nxt = ST_FINISH;
        end else begin
          mode_nxt  = MODE_ASSIGN;
          s_nxt     = '0;
          f_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_UPDATE, ST_DWAIT: begin
        if ((state_r == ST_UPDATE) && (mcnt_r[uc_c_r] != '0)) begin
          state_nxt = ST_DWAIT;
        end else if ((state_r == ST_DWAIT) && !div_done) begin
          state_nxt = ST_DWAIT;
        end else begin
          if ((state_r == ST_DWAIT) && (div_quo != cent_r[uc_c_r][uc_f_r])) begin
            changed_nxt = 1'b1;
          end
          state_nxt = ST_UPDATE;
          uc_f_nxt  = uc_f_r + 1'b1;
          if (uc_f_r == FIW'(NUM_FEATURES - 1)) begin
            uc_f_nxt = '0;
            uc_c_nxt = uc_c_r + 1'b1;
            if (uc_c_r == CIW'(NUM_CLUSTERS - 1)) begin
              state_nxt = ST_ITEREND;
            end
          end
        end
      end
      ST_ITEREND: begin
        it_nxt    = it_r + 1'b1;
        state_nxt = ST_ITER;
        if (!changed_r) begin
          uc_nxt = (uc_r == 2'd3) ? 2'd3 : uc_r + 1'b1;
          if (uc_r >= 2'd1) begin
            conv_pend_nxt = 1'b1;
            state_nxt     = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        conv_nxt     = conv_pend_r;
        used_nxt     = it_r;
        out_vld_nxt  = 1'b1;
        out_data_nxt = {7'd0, it_r, conv_pend_r, 16'd0};
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_LOAD;
      s_r         <= '0;
      f_r         <= '0;
      n_last_r    <= '0;
      pick_r      <= '0;
      best_r      <= '0;
      have_r      <= 1'b0;
      c_idx_r     <= '0;
      it_r        <= '0;
      uc_r        <= '0;
      changed_r   <= 1'b0;
      conv_pend_r <= 1'b0;
      uc_c_r      <= '0;
      uc_f_r      <= '0;
      conv_r      <= 1'b0;
      used_r      <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      s_r         <= s_nxt;
      f_r         <= f_nxt;
      n_last_r    <= n_last_nxt;
      pick_r      <= pick_nxt;
      best_r      <= best_nxt;
      have_r      <= have_nxt;
      c_idx_r     <= c_idx_nxt;
      it_r        <= it_nxt;
      uc_r        <= uc_nxt;
      changed_r   <= changed_nxt;
      conv_pend_r <= conv_pend_nxt;
      uc_c_r      <= uc_c_nxt;
      uc_f_r      <= uc_f_nxt;
      conv_r      <= conv_nxt;
      used_r      <= used_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Sample memory: written by feature requests, read while walking samples.
  assign smem_we    = in_acc && (in_cmd == CMD_WRITE) && (32'(in_si) < SAMPLE_DEPTH) &&
                      (32'(in_fi) < NUM_FEATURES);
  assign smem_waddr = {in_si[SIW-1:0], in_fi[FIW-1:0]};

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_waddr] <= in_fv[FEATURE_WIDTH-1:0];
    end
    smem_q_r <= smem[{s_r, f_r}];
  end

  // Label memory with per-entry valid bits so unwritten labels read zero.
  always_ff @(posedge clk) begin
    if ((state_r == ST_EVAL) && (mode_r == MODE_ASSIGN)) begin
      lmem[s_r] <= bc;
    end
    lmem_q_r <= lmem[in_si[SIW-1:0]];
    lvld_q_r <= lvld_r[in_si[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvld_r <= '0;
    end else if ((state_r == ST_EVAL) && (mode_r == MODE_ASSIGN)) begin
      lvld_r[s_r] <= 1'b1;
    end
  end

  // Read pipeline: memory data, then squared differences, then accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_ISSUE);
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_f_r <= f_r;
    sq_f_r <= rd_f_r;
    if (rd_vld_r) begin
      buf_r[rd_f_r] <= smem_q_r;
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        logic signed [FEATURE_WIDTH:0] diff;
        logic [FEATURE_WIDTH:0]        mag;
        diff    = {smem_q_r[FEATURE_WIDTH-1], smem_q_r} -
                  {cent_r[c][rd_f_r][FEATURE_WIDTH-1], cent_r[c][rd_f_r]};
        mag     = diff[FEATURE_WIDTH] ? (-diff) : diff;
        sq_r[c] <= mag[FEATURE_WIDTH-1:0] * mag[FEATURE_WIDTH-1:0];
      end
    end
    if (sq_vld_r) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        dist_r[c] <= ((sq_f_r == '0) ? '0 : dist_r[c]) + DISTW'(sq_r[c]);
      end
    end
  end

  // Centroid registers: seeding copies, mean update writes divider results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        for (int f = 0; f < NUM_FEATURES; f++) begin
          cent_r[c][f] <= '0;
        end
      end
    end else if ((state_r == ST_EVAL) && (mode_r == MODE_LOAD)) begin
      for (int f = 0; f < NUM_FEATURES; f++) begin
        cent_r[c_idx_r][f] <= buf_r[f];
      end
    end else if ((state_r == ST_DWAIT) && div_done) begin
      cent_r[uc_c_r][uc_f_r] <= div_quo;
    end
  end

  // Member sums and counts: cleared per iteration, added per assigned sample.
  always_ff @(posedge clk) begin
    if ((state_r == ST_ITER) || !rst_n) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        mcnt_r[c] <= '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
          sum_r[c][f] <= '0;
        end
      end
    end else if ((state_r == ST_EVAL) && (mode_r == MODE_ASSIGN)) begin
      mcnt_r[bc] <= mcnt_r[bc] + 1'b1;
      for (int f = 0; f < NUM_FEATURES; f++) begin
        sum_r[bc][f] <= sum_r[bc][f] + SUMW'(buf_r[f]);
      end
    end
  end

  // Shared divider for the mean update.
  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[uc_c_r][uc_f_r]),
    .divisor  (mcnt_r[uc_c_r]),
    .quotient (div_quo),
    .done     (div_done)
  );

endmodule

`default_nettype wire

// ===== rtl/kmc_checker.sv =====
// ----------------------------------------------------------------------------
// kmc_checker: port-level checks for the k-means cluster engine
// Watches the stream ports and flags handshake or response slips.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [31:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata
);
  import kmc_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result holds its data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A feature write answers in the next cycle with a zero read value.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == CMD_WRITE)
    |=> out_tvalid && (out_tdata[15:0] == 16'd0))
    else $error("write request not answered with zero");

  // A run request cannot finish in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == CMD_RUN) |=> !out_tvalid)
    else $error("run request answered too early");

endmodule

bind kmeans_cluster_engine kmc_checker u_kmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== sim/kmeans_cluster_engine_test.sv =====
// ----------------------------------------------------------------------------
// kmeans_cluster_engine_test: self-checking bench for the k-means engine
// Loads sample features, runs clustering under several register settings and
// reads labels and centroids back. An internal predictor computes the
// expected response for every accepted request; a monitor checks each
// response field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module kmeans_cluster_engine_test;
  import kmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000000;

  // Packed from the top down: iterations_used, converged, read_value.
  typedef struct packed {
    logic [7:0]         iterations_used;
    logic               converged;
    logic signed [15:0] read_value;
  } response_t;

  typedef struct {
    bit       is_cfg;
    bit [1:0] cfg_reg;
    bit [8:0] cfg_value;
    bit [31:0] data;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  kmeans_cluster_engine i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predictor state.
  longint    sample_mem [SAMPLE_DEPTH][NUM_FEATURES];
  longint    centroid   [NUM_CLUSTERS][NUM_FEATURES];
  bit [7:0]  label_mem  [SAMPLE_DEPTH];
  bit        last_converged;
  bit [7:0]  last_iterations;
  int        cnt_reg, seed_reg, limit_reg;

  response_t expected_responses[$];
  request_t  pending_requests[$];
  int        mismatches;
  int        send_idle_pct, recv_idle_pct;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint distance_sq(longint a[NUM_FEATURES], longint b[NUM_FEATURES]);
    longint acc;
    acc = 0;
    for (int f = 0; f < NUM_FEATURES; f++) acc += (a[f] - b[f]) * (a[f] - b[f]);
    return acc;
  endfunction

  function automatic void predict_clustering();
    int       n, pick, unchanged, used, best_c;
    bit       conv, same;
    longint   best, nearest, d, best_d;
    longint   sums [NUM_CLUSTERS][NUM_FEATURES];
    longint   counts [NUM_CLUSTERS];
    longint   prev [NUM_CLUSTERS][NUM_FEATURES];
    n = (cnt_reg == 0) ? 1 : (cnt_reg > SAMPLE_DEPTH ? SAMPLE_DEPTH : cnt_reg);
    pick = (seed_reg < n) ? seed_reg : 0;
    // Farthest-point seeding; the first sample wins a tie.
    for (int c = 0; c < NUM_CLUSTERS; c++) begin
      centroid[c] = sample_mem[pick];
      if (c + 1 < NUM_CLUSTERS) begin
        best = -1;
        for (int s = 0; s < n; s++) begin
          nearest = -1;
          for (int k = 0; k <= c; k++) begin
            d = distance_sq(sample_mem[s], centroid[k]);
            if (nearest < 0 || d < nearest) nearest = d;
          end
          if (nearest > best) begin
            best = nearest;
            pick = s;
          end
        end
      end
    end
    unchanged = 0;
    used = 0;
    conv = 1'b0;
    for (int it = 0; it < limit_reg; it++) begin
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        counts[c] = 0;
        for (int f = 0; f < NUM_FEATURES; f++) sums[c][f] = 0;
      end
      for (int s = 0; s < n; s++) begin
        best_c = 0;
        best_d = distance_sq(sample_mem[s], centroid[0]);
        for (int c = 1; c < NUM_CLUSTERS; c++) begin
          d = distance_sq(sample_mem[s], centroid[c]);
          if (d < best_d) begin
            best_d = d;
            best_c = c;
          end
        end
        label_mem[s] = best_c;
        counts[best_c]++;
        for (int f = 0; f < NUM_FEATURES; f++) sums[best_c][f] += sample_mem[s][f];
      end
      prev = centroid;
      same = 1'b1;
      // SystemVerilog division truncates toward zero, like the hardware.
      for (int c = 0; c < NUM_CLUSTERS; c++)
        if (counts[c] != 0)
          for (int f = 0; f < NUM_FEATURES; f++) begin
            centroid[c][f] = sums[c][f] / counts[c];
            if (centroid[c][f] != prev[c][f]) same = 1'b0;
          end
      used = it + 1;
      if (same) begin
        if (unchanged < 3) unchanged++;
        if (unchanged >= 2) begin
          conv = 1'b1;
          break;
        end
      end
    end
    last_converged = conv;
    last_iterations = used[7:0];
  endfunction

  function automatic response_t predict_response(bit [31:0] data);
    response_t r;
    bit [1:0] cmd;
    int si, ci, fi;
    cmd = data[1:0];
    si = data[9:2];
    ci = data[12:10];
    fi = data[15:13];
    r.read_value = '0;
    case (cmd)
      CMD_WRITE: begin
        if (si < SAMPLE_DEPTH && fi < NUM_FEATURES)
          sample_mem[si][fi] = longint'($signed(data[31:16]));
      end
      CMD_RUN: predict_clustering();
      CMD_RLABEL: begin
        if (si < SAMPLE_DEPTH) r.read_value = label_mem[si];
      end
      default: begin
        if (ci < NUM_CLUSTERS && fi < NUM_FEATURES) r.read_value = centroid[ci][fi];
      end
    endcase
    r.converged = last_converged;
    r.iterations_used = last_iterations;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic bit [31:0] pack_request(bit [1:0] cmd, bit [7:0] si, bit [2:0] ci,
                                             bit [2:0] fi, bit [15:0] value);
    return {value, fi, ci, si, cmd};
  endfunction

  function automatic void queue_request(bit [31:0] data);
    request_t r;
    r.is_cfg = 1'b0;
    r.data = data;
    pending_requests.push_back(r);
  endfunction

  function automatic void queue_config(bit [1:0] reg_index, bit [8:0] value);
    request_t r;
    r.is_cfg = 1'b1;
    r.cfg_reg = reg_index;
    r.cfg_value = value;
    pending_requests.push_back(r);
  endfunction

  // Fills samples [0, n) with random points around two centers (-1000 and 1000), or fully random values when wide.
  function automatic void queue_sample_load(int n, bit wide);
    int spread;
    int center;
    spread = wide ? 32767 : 200;
    for (int s = 0; s < n; s++) begin
      center = $urandom_range(0, 1) ? 1000 : -1000;
      for (int f = 0; f < NUM_FEATURES; f++)
        queue_request(pack_request(CMD_WRITE, s, $urandom, f,
          wide ? 16'($urandom) : 16'(center + int'($urandom_range(0, 2 * spread)) - spread)));
    end
  endfunction

  function automatic void queue_reads(int n, int count);
    for (int i = 0; i < count; i++)
      if ($urandom_range(0, 1))
        queue_request(pack_request(CMD_RLABEL, $urandom_range(0, n - 1), $urandom, $urandom, $urandom));
      else
        queue_request(pack_request(CMD_RCENT, $urandom, $urandom, $urandom, $urandom));
  endfunction

  // Driver: feeds requests and configuration writes, changing at the falling edge.
  request_t current;
  bit       have_current;
  bit       taken;
  int       settle_cycles;

  // Remembers whether the last rising edge accepted a request or a write.
  always @(posedge clk) begin
    if (rst_n) taken = (in_tvalid && in_tready) || (cfg_valid && cfg_ready);
  end

  always @(negedge clk) begin
    bit v_in, v_cfg;
    if (rst_n) begin
      if (taken) begin
        have_current = 1'b0;
        taken = 1'b0;
      end
      if (!have_current && pending_requests.size() != 0) begin
        current = pending_requests.pop_front();
        have_current = 1'b1;
        settle_cycles = 0;
      end
      v_in = 1'b0;
      v_cfg = 1'b0;
      if (have_current) begin
        if (current.is_cfg) begin
          // Configuration only while the engine is idle.
          if (expected_responses.size() == 0) settle_cycles++;
          if (settle_cycles > 4) begin
            v_cfg = 1'b1;
            cfg_index <= current.cfg_reg;
            cfg_data  <= current.cfg_value;
          end
        end else if (in_tvalid || ($urandom_range(0, 99) >= send_idle_pct)) begin
          // An offered request stays offered until it is accepted.
          v_in = 1'b1;
          in_tdata <= current.data;
        end
      end
      in_tvalid <= v_in;
      cfg_valid <= v_cfg;
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor and predictor update at the rising edge.
  always @(posedge clk) begin
    response_t got, want;
    bit progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          CFG_SAMPLE_COUNT: cnt_reg = cfg_data;
          CFG_SEED_SAMPLE:  seed_reg = cfg_data[7:0];
          CFG_ITER_LIMIT:   limit_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        progress = 1'b1;
        expected_responses.push_back(predict_response(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        progress = 1'b1;
        got = out_tdata[24:0];
        if (out_tdata[31:25] != 0) report_mismatch("fill bits", out_tdata[31:25], 0);
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response", out_tdata, 0);
        end else begin
          want = expected_responses.pop_front();
          if (got.read_value != want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.converged != want.converged)
            report_mismatch("converged", got.converged, want.converged);
          if (got.iterations_used != want.iterations_used)
            report_mismatch("iterations_used", got.iterations_used, want.iterations_used);
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Builds one phase of stimulus with the given register settings.
  function automatic void queue_phase(int n, int seed, int limit, bit wide, int runs);
    int n_used;
    n_used = (n == 0) ? 1 : ((n > SAMPLE_DEPTH) ? SAMPLE_DEPTH : n);
    queue_config(CFG_SAMPLE_COUNT, n);
    queue_config(CFG_SEED_SAMPLE, seed);
    queue_config(CFG_ITER_LIMIT, limit);
    for (int r = 0; r < runs; r++) begin
      queue_sample_load(n_used, wide);
      queue_request(pack_request(CMD_RUN, $urandom, $urandom, $urandom, $urandom));
      queue_reads(n_used, 12);
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SAMPLE_COUNT;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    have_current = 1'b0;
    taken = 1'b0;
    settle_cycles = 0;
    cnt_reg = 256;
    seed_reg = 0;
    limit_reg = 100;
    last_converged = 1'b0;
    last_iterations = '0;
    for (int s = 0; s < SAMPLE_DEPTH; s++) begin
      label_mem[s] = '0;
      for (int f = 0; f < NUM_FEATURES; f++) sample_mem[s][f] = 0;
    end
    for (int c = 0; c < NUM_CLUSTERS; c++)
      for (int f = 0; f < NUM_FEATURES; f++) centroid[c][f] = 0;
    send_idle_pct = 34;
    recv_idle_pct = 49;

    // Directed: reads after reset, out-of-range reads and writes, extreme values.
    queue_request(pack_request(CMD_RLABEL, 8'd255, 3'd0, 3'd0, 16'h0));
    queue_request(pack_request(CMD_RCENT, 8'd0, 3'd7, 3'd7, 16'hffff));
    queue_request(pack_request(CMD_RCENT, 8'd0, 3'd1, 3'd3, 16'h0));
    queue_config(CFG_SAMPLE_COUNT, 9'd2);
    queue_config(CFG_SEED_SAMPLE, 9'd255);   // seed beyond count falls back to 0
    queue_config(CFG_ITER_LIMIT, 9'd0);      // seeding only
    for (int f = 0; f < NUM_FEATURES; f++) begin
      queue_request(pack_request(CMD_WRITE, 8'd0, 3'd0, f, 16'h8000));
      queue_request(pack_request(CMD_WRITE, 8'd1, 3'd7, f, 16'h7fff));
    end
    queue_request(pack_request(CMD_WRITE, 8'd0, 3'd0, 3'd7, 16'h1234)); // ignored feature
    queue_request(pack_request(CMD_RUN, 8'd0, 3'd0, 3'd0, 16'h0));
    queue_request(pack_request(CMD_RCENT, 8'd0, 3'd1, 3'd0, 16'h0));
    queue_request(pack_request(CMD_RLABEL, 8'd1, 3'd0, 3'd0, 16'h0));
    queue_config(CFG_ITER_LIMIT, 9'd255);
    queue_request(pack_request(CMD_RUN, 8'd0, 3'd0, 3'd0, 16'h0));
    queue_request(pack_request(CMD_RLABEL, 8'd1, 3'd0, 3'd0, 16'h0));
    queue_request(pack_request(CMD_RCENT, 8'd0, 3'd0, 3'd3, 16'h0));
    queue_request(pack_request(CMD_RCENT, 8'd0, 3'd1, 3'd3, 16'h0));

    // Random phases with varied settings; small sample counts keep runs short.
    queue_phase(1, 0, 1, 1'b1, 2);                      // single sample
    queue_phase(0, 0, 3, 1'b0, 1);                      // zero count acts as one
    queue_phase(12, $urandom_range(0, 11), 255, 1'b0, 1);
    queue_phase(10, 200, 2, 1'b1, 2);                   // seed beyond count
    queue_phase(16, $urandom_range(0, 15), 1, 1'b0, 1);
    queue_phase(8, 3, 100, 1'b1, 2);
    queue_phase(20, $urandom_range(0, 19), 255, 1'b0, 1);
    queue_phase(6, 5, 4, 1'b1, 2);
    // Wait for the first half to drain before switching idle rates.
    wait (pending_requests.size() == 0 && expected_responses.size() == 0);
    send_idle_pct = 49;
    recv_idle_pct = 34;
    queue_phase(14, $urandom_range(0, 13), 255, 1'b0, 2);
    queue_phase(9, 1, 5, 1'b1, 2);
    wait (pending_requests.size() == 0 && expected_responses.size() == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase(18, $urandom_range(0, 17), 50, 1'b0, 1);
    queue_phase(7, 0, 255, 1'b1, 2);
    wait (pending_requests.size() == 0 && !have_current && expected_responses.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end
endmodule
